FILE: rtl/dbmc_pkg.sv
// Shared types, codes and the command clamp and duty scaling functions for the dual bridge controller.
`timescale 1ns / 1ps
package dbmc_pkg;

  typedef enum logic [2:0] {
    ACT_INIT     = 3'd0,
    ACT_SLEEP    = 3'd1,
    ACT_CLR_FLT  = 3'd2,
    ACT_SET_MODE = 3'd3,
    ACT_DC       = 3'd4,
    ACT_PARALLEL = 3'd5,
    ACT_STEPPER  = 3'd6,
    ACT_BRAKE    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    MODE_SLEEP    = 2'd0,
    MODE_DUAL     = 2'd1,
    MODE_STEPPER  = 2'd2,
    MODE_PARALLEL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_INIT    = 2'd1,
    ST_PARAM       = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE_PINS  = 2'd0;
  localparam logic [1:0] CFG_SLEEP_PIN  = 2'd1;
  localparam logic [1:0] CFG_FAULT_PIN  = 2'd2;

  localparam logic [7:0] PWM_FULL = 8'd255;
  localparam logic signed [7:0] CMD_MAX = 8'sd100;
  localparam logic signed [7:0] CMD_MIN = -8'sd100;

  // floor(mag * 255 / 100) == (mag * 334305) >> 17 for mag in 0..100
  localparam logic [18:0] DUTY_RECIP = 19'd334305;
  localparam int          DUTY_SHIFT = 17;

  typedef struct packed {
    action_t           action;
    mode_t             mode_request;
    logic              motor_select;
    logic signed [7:0] command_a;
    logic signed [7:0] command_b;
    logic              fault_pin_low;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        duty_in1;
    logic [7:0]        duty_in2;
    logic [7:0]        duty_in3;
    logic [7:0]        duty_in4;
    logic              parallel_select_pin;
    logic              wake_pin;
    mode_t             current_mode;
    logic              awake;
    logic              fault_flag;
    logic signed [7:0] readback_a;
    logic signed [7:0] readback_b;
  } out_item_t;

  typedef struct packed {
    logic mode_pins_present;
    logic sleep_pin_present;
    logic fault_pin_present;
  } cfg_t;

  function automatic logic signed [7:0] clamp_cmd(logic signed [7:0] raw);
    logic signed [7:0] v;
    v = raw;
    if (raw > CMD_MAX) v = CMD_MAX;
    if (raw < CMD_MIN) v = CMD_MIN;
    return v;
  endfunction

  // mag is 0..100
  function automatic logic [7:0] duty_of(logic [6:0] mag);
    logic [25:0] prod;
    prod = {19'd0, mag} * {7'd0, DUTY_RECIP};
    return prod[DUTY_SHIFT+7:DUTY_SHIFT];
  endfunction

endpackage

FILE: rtl/dual_bridge_motor_mode_controller_core.sv
// Top level of the dual H-bridge motor mode controller.
`timescale 1ns / 1ps
//
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------
// in_      | input     | in_valid / in_ready  | in_item  (action, mode, commands)
// out_     | output    | out_valid / out_ready| out_item (status, pins, telemetry)
// cfg_     | input     | cfg_we, no wait      | cfg_index, cfg_wdata (pin present)
//
// The controller decodes each command and updates its state at the edge of the
// transfer; the result is registered in a two-entry output queue and shown on out_
// once earlier results are taken. A new command can follow every cycle while the
// queue has room: in_ready drops only when both queue entries hold untaken results.
// Reset (synchronous, active low) clears the state, empties the queue and sets all
// three pin-present registers to 1.
//
module dual_bridge_motor_mode_controller_core (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_valid,
  output logic                in_ready,
  input  dbmc_pkg::in_item_t  in_item,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output dbmc_pkg::out_item_t out_item,
  // configuration write port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [0:0]          cfg_wdata
);
  import dbmc_pkg::*;

  logic      accept;
  logic      q_full;
  out_item_t res;

  // accept whenever the queue has a free slot
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  dbmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (in_item),
    .res       (res)
  );

  dbmc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_item (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
  // with an empty queue, a command is never refused
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("ready low with empty queue");
  // awake in a result always pairs with a non-sleep mode
  a_awake_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.awake) |-> (out_item.current_mode != MODE_SLEEP))
    else $error("awake reported in sleep mode");

endmodule

FILE: rtl/dbmc_ctrl.sv
// Controller state registers and the one-pass action decode that updates them.
`timescale 1ns / 1ps
module dbmc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [0:0]         cfg_wdata,
  input  logic               accept,
  input  dbmc_pkg::in_item_t item,
  output dbmc_pkg::out_item_t res
);
  import dbmc_pkg::*;

  cfg_t              cfg_r;
  logic              init_r, init_nxt;
  mode_t             mode_r, mode_nxt;
  logic [7:0]        duty_r [4];
  logic [7:0]        duty_nxt [4];
  logic              par_r, par_nxt;
  logic              wake_r, wake_nxt;
  logic signed [7:0] cmd_r [2];
  logic signed [7:0] cmd_nxt [2];
  status_t           status;

  logic signed [7:0] ca, cb;
  logic [6:0]        mag_a, mag_b;
  logic [7:0]        duty_a, duty_b;

  assign ca    = clamp_cmd(item.command_a);
  assign cb    = clamp_cmd(item.command_b);
  assign mag_a = ca[7] ? 7'(-ca) : ca[6:0];
  assign mag_b = cb[7] ? 7'(-cb) : cb[6:0];
  assign duty_a = duty_of(mag_a);
  assign duty_b = duty_of(mag_b);

  always_comb begin
    init_nxt = init_r;
    mode_nxt = mode_r;
    par_nxt  = par_r;
    wake_nxt = wake_r;
    for (int i = 0; i < 4; i++) duty_nxt[i] = duty_r[i];
    for (int i = 0; i < 2; i++) cmd_nxt[i] = cmd_r[i];
    status = ST_OK;

    unique case (item.action)
      ACT_INIT: begin
        if (!init_r) begin
          if (cfg_r.sleep_pin_present) wake_nxt = 1'b0;
          if (cfg_r.mode_pins_present) par_nxt = 1'b0;
          for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
          mode_nxt = cfg_r.sleep_pin_present ? MODE_SLEEP : MODE_DUAL;
          init_nxt = 1'b1;
        end
      end
      ACT_SLEEP: begin
        if (!init_r) begin
          status = ST_NOT_INIT;
        end else begin
          for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
          if (cfg_r.sleep_pin_present) wake_nxt = 1'b0;
          mode_nxt = MODE_SLEEP;
        end
      end
      ACT_CLR_FLT: begin
        if (!init_r) begin
          status = ST_NOT_INIT;
        end else begin
          for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
          if (!cfg_r.sleep_pin_present) begin
            status = ST_NOT_PRESENT;
          end else if (mode_r != MODE_SLEEP) begin
            if (cfg_r.mode_pins_present) par_nxt = (mode_r == MODE_PARALLEL);
            wake_nxt = 1'b1;
          end else begin
            wake_nxt = 1'b0;
          end
        end
      end
      ACT_SET_MODE: begin
        if (!init_r) begin
          status = ST_NOT_INIT;
        end else if (item.mode_request == MODE_SLEEP) begin
          for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
          if (cfg_r.sleep_pin_present) wake_nxt = 1'b0;
          mode_nxt = MODE_SLEEP;
        end else if (!cfg_r.mode_pins_present || !cfg_r.sleep_pin_present) begin
          // missing pins: only the non-parallel modes can be entered
          if (item.mode_request == MODE_PARALLEL) begin
            status = ST_NOT_PRESENT;
          end else begin
            for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
            for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
            mode_nxt = item.mode_request;
          end
        end else begin
          for (int i = 0; i < 4; i++) duty_nxt[i] = '0;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
          par_nxt  = (item.mode_request == MODE_PARALLEL);
          wake_nxt = 1'b1;
          mode_nxt = item.mode_request;
        end
      end
      ACT_DC: begin
        if (!init_r || mode_r != MODE_DUAL) begin
          status = ST_PARAM;
        end else if (item.motor_select) begin
          duty_nxt[2] = (ca > 0) ? duty_a : '0;
          duty_nxt[3] = ca[7]    ? duty_a : '0;
          cmd_nxt[1]  = ca;
        end else begin
          duty_nxt[0] = (ca > 0) ? duty_a : '0;
          duty_nxt[1] = ca[7]    ? duty_a : '0;
          cmd_nxt[0]  = ca;
        end
      end
      ACT_PARALLEL: begin
        if (!init_r || mode_r != MODE_PARALLEL) begin
          status = ST_PARAM;
        end else begin
          duty_nxt[0] = (ca > 0) ? duty_a : '0;
          duty_nxt[1] = ca[7]    ? duty_a : '0;
          duty_nxt[2] = (ca > 0) ? duty_a : '0;
          duty_nxt[3] = ca[7]    ? duty_a : '0;
          cmd_nxt[0]  = ca;
        end
      end
      ACT_STEPPER: begin
        if (!init_r || mode_r != MODE_STEPPER) begin
          status = ST_PARAM;
        end else begin
          duty_nxt[0] = (ca > 0) ? duty_a : '0;
          duty_nxt[1] = ca[7]    ? duty_a : '0;
          duty_nxt[2] = (cb > 0) ? duty_b : '0;
          duty_nxt[3] = cb[7]    ? duty_b : '0;
          cmd_nxt[0]  = ca;
          cmd_nxt[1]  = cb;
        end
      end
      ACT_BRAKE: begin
        if (!init_r) begin
          status = ST_NOT_INIT;
        end else if (mode_r != MODE_SLEEP) begin
          for (int i = 0; i < 4; i++) duty_nxt[i] = PWM_FULL;
          for (int i = 0; i < 2; i++) cmd_nxt[i] = '0;
        end
      end
    endcase
  end

  always_comb begin
    res.status              = status;
    res.duty_in1            = duty_nxt[0];
    res.duty_in2            = duty_nxt[1];
    res.duty_in3            = duty_nxt[2];
    res.duty_in4            = duty_nxt[3];
    res.parallel_select_pin = par_nxt;
    res.wake_pin            = wake_nxt;
    res.current_mode        = mode_nxt;
    res.awake               = init_nxt && (mode_nxt != MODE_SLEEP);
    res.fault_flag          = init_nxt && cfg_r.fault_pin_present && item.fault_pin_low;
    res.readback_a          = cmd_nxt[0];
    res.readback_b          = cmd_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '{mode_pins_present: 1'b1, sleep_pin_present: 1'b1, fault_pin_present: 1'b1};
      init_r <= 1'b0;
      mode_r <= MODE_SLEEP;
      par_r  <= 1'b0;
      wake_r <= 1'b0;
      for (int i = 0; i < 4; i++) duty_r[i] <= '0;
      for (int i = 0; i < 2; i++) cmd_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE_PINS: cfg_r.mode_pins_present <= cfg_wdata[0];
          CFG_SLEEP_PIN: cfg_r.sleep_pin_present <= cfg_wdata[0];
          CFG_FAULT_PIN: cfg_r.fault_pin_present <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        init_r <= init_nxt;
        mode_r <= mode_nxt;
        par_r  <= par_nxt;
        wake_r <= wake_nxt;
        for (int i = 0; i < 4; i++) duty_r[i] <= duty_nxt[i];
        for (int i = 0; i < 2; i++) cmd_r[i] <= cmd_nxt[i];
      end
    end
  end

  // A bridge drives both inputs only when braking at full duty.
  a_bridge_a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (duty_r[0] != '0 && duty_r[1] != '0) |-> (duty_r[0] == PWM_FULL && duty_r[1] == PWM_FULL))
    else $error("bridge A drives both inputs outside brake");
  a_bridge_b_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (duty_r[2] != '0 && duty_r[3] != '0) |-> (duty_r[2] == PWM_FULL && duty_r[3] == PWM_FULL))
    else $error("bridge B drives both inputs outside brake");
  // A rejected drive command leaves the duties alone.
  a_param_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.status == ST_PARAM) |=>
      ($stable(duty_r[0]) && $stable(duty_r[1]) && $stable(duty_r[2]) && $stable(duty_r[3])))
    else $error("duties changed on rejected drive command");
  // Without init, only init can set the flag.
  a_init_only: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !init_r && item.action != ACT_INIT) |=> !init_r)
    else $error("initialised flag set by non-init action");

endmodule

FILE: rtl/dbmc_out_fifo.sv
// Two-entry result queue between the controller and the result channel.
`timescale 1ns / 1ps
module dbmc_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dbmc_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output dbmc_pkg::out_item_t out_item
);
  import dbmc_pkg::*;

  out_item_t   mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_item  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result queue overflow");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !out_valid) |=> (out_valid && out_item == $past(push_item)))
    else $error("pushed result not presented");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step with count");

endmodule
